// ===== sv/slotted_page_record_directory_assert.svh =====
// Assertion helpers for the page directory RTL.
`ifndef SLOTTED_PAGE_RECORD_DIRECTORY_ASSERT_SVH
`define SLOTTED_PAGE_RECORD_DIRECTORY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sprd_pkg.sv =====
package sprd_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  position;
      logic [63:0] record_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  record_count;
      logic [63:0] read_value;
      logic        page_dirty;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DONE
   } state_type;

endpackage

// ===== sv/sprd_ram.sv =====
module sprd_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/slotted_page_record_directory.sv =====
// Slotted page with an ordered slot directory. Each item (insert, delete or
// read at a logical position) is accepted and then passes an execute state
// that updates the directory and count and issues the single record memory
// access, and a finish state that returns the record read or moves the last
// physical record into the slot a delete freed. The finish state follows
// from the registered read of the record memory and the read-then-write
// it needs for a delete. The result sits in an output
// register, so the next item is accepted while a finished result still
// waits under stall. Records stay compact in physical slots 0 to count-1,
// so the record memory needs no clearing pass after reset: the block takes
// items from the first cycle after reset.
`include "slotted_page_record_directory_assert.svh"

module slotted_page_record_directory #(
   parameter int SLOTS       = 16,
   parameter int RECORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sprd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sprd_pkg::rsp_type rsp_data
);

   import sprd_pkg::*;

   // index width, count width and a compare width that also holds a position
   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int WW   = (CW > 4) ? CW : 4;

   state_type state_ff, state_in;

   // captured item
   logic [1:0]             op_ff;
   logic [3:0]             pos_ff;
   logic [RECORD_BITS-1:0] val_ff;

   // page state: count and dirty mark in flops, directory in flops
   logic [CW-1:0]   count_ff, count_in;
   logic            dirty_ff, dirty_in;
   logic [IDXW-1:0] dir_ff [SLOTS];
   logic [IDXW-1:0] dir_in [SLOTS];
   logic [IDXW-1:0] dir_up [SLOTS];
   logic [IDXW-1:0] dir_dn [SLOTS];

   // carried from execute to finish
   logic [1:0]      status_ff, status_in;
   logic            rd_sel_ff, rd_sel_in;
   logic            move_ff, move_in;
   logic [IDXW-1:0] freed_ff;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // decode of the captured item against the current page
   logic [WW-1:0]          pos_w, cnt_w;
   logic [IDXW-1:0]        pos_idx, dir_at_pos, last_idx;
   logic [CW-1:0]          last;
   logic                   full, ins_ok, del_ok, rd_ok;
   logic                   in_exec, done_go;

   // record memory port
   logic                   mem_wr_en, mem_rd_en;
   logic [IDXW-1:0]        mem_wr_addr, mem_rd_addr;
   logic [RECORD_BITS-1:0] mem_wr_data, mem_rd_data;
   logic [63:0]            rd_ext;

   sprd_ram #(
      .DEPTH (SLOTS),
      .WIDTH (RECORD_BITS)
   ) u_records (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------------
   // Decode. Full is tested before the position on insert; delete and read
   // need a position below the count, so an empty page always answers range.
   // ---------------------------------------------------------------------
   always_comb begin
      pos_w      = WW'(pos_ff);
      cnt_w      = WW'(count_ff);
      pos_idx    = pos_w[IDXW-1:0];
      dir_at_pos = dir_ff[pos_idx];
      last       = count_ff - CW'(1);
      last_idx   = last[IDXW-1:0];
      full       = (count_ff == CW'(SLOTS));
      ins_ok     = (op_ff == OP_INSERT) && !full && (pos_w <= cnt_w);
      del_ok     = (op_ff == OP_DELETE) && (pos_w < cnt_w);
      rd_ok      = (op_ff == OP_READ) && (pos_w < cnt_w);
      in_exec    = (state_ff == S_EXEC);
      done_go    = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      case (op_ff)
         OP_INSERT: status_in = full ? ST_FULL : ((pos_w > cnt_w) ? ST_RANGE : ST_OK);
         OP_DELETE: status_in = del_ok ? ST_OK : ST_RANGE;
         OP_READ:   status_in = rd_ok ? ST_OK : ST_RANGE;
         default:   status_in = ST_OK;
      endcase
   end

   // ---------------------------------------------------------------------
   // Directory update. Insert shifts entries above the position up and
   // points the position at the next free physical slot. Delete shifts the
   // entries above the position down and renumbers the entry that named the
   // last physical slot to the freed one. Entries at or above the count are
   // never read before they are written again, so they are left to float.
   // ---------------------------------------------------------------------
   always_comb begin
      dir_up[0] = dir_ff[0];
      for (int i = 1; i < SLOTS; i++) begin
         dir_up[i] = dir_ff[i-1];
      end
      for (int i = 0; i < SLOTS - 1; i++) begin
         dir_dn[i] = dir_ff[i+1];
      end
      dir_dn[SLOTS-1] = dir_ff[SLOTS-1];
   end

   always_comb begin
      logic [IDXW-1:0] v;
      v = '0;
      for (int i = 0; i < SLOTS; i++) begin
         dir_in[i] = dir_ff[i];
         if (in_exec && ins_ok) begin
            if (WW'(i) == pos_w) begin
               dir_in[i] = count_ff[IDXW-1:0];
            end else if (WW'(i) > pos_w) begin
               dir_in[i] = dir_up[i];
            end
         end else if (in_exec && del_ok) begin
            v = (WW'(i) >= pos_w) ? dir_dn[i] : dir_ff[i];
            if (v == last_idx) begin
               v = dir_at_pos;
            end
            dir_in[i] = v;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      dirty_in = dirty_ff;
      if (in_exec && ins_ok) begin
         count_in = count_ff + CW'(1);
         dirty_in = 1'b1;
      end else if (in_exec && del_ok) begin
         count_in = last;
         dirty_in = 1'b1;
      end
   end

   // a delete moves a record only when the freed slot is not the last one
   assign move_in   = del_ok && (dir_at_pos != last_idx);
   assign rd_sel_in = rd_ok;

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_EXEC;
         S_EXEC:  state_in = S_DONE;
         S_DONE:  if (done_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs. Execute writes an inserted record or reads the
   // record needed; finish writes the moved record back. The two writes
   // never fall in the same cycle, and the next item reaches the memory
   // only after the write-back, so no forwarding is needed.
   // ---------------------------------------------------------------------
   always_comb begin
      req_stall   = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[IDXW-1:0];
      mem_wr_data = val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = dir_at_pos;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_EXEC: begin
            mem_wr_en = ins_ok;
            mem_rd_en = del_ok || rd_ok;
            if (op_ff == OP_DELETE) begin
               mem_rd_addr = last_idx;
            end
         end
         S_DONE: begin
            mem_wr_en   = done_go && move_ff;
            mem_wr_addr = freed_ff;
            mem_wr_data = mem_rd_data;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register: load on finish, drop once taken.
   // ---------------------------------------------------------------------
   assign rd_ext = 64'(mem_rd_data);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (done_go) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = status_ff;
         rsp_data_in.record_count  = 5'(count_ff);
         rsp_data_in.read_value    = rd_sel_ff ? rd_ext : 64'd0;
         rsp_data_in.page_dirty    = dirty_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dirty_ff     <= 1'b0;
         move_ff      <= 1'b0;
         rd_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_exec) begin
            move_ff   <= move_in;
            rd_sel_ff <= rd_sel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff  <= req_data.op;
         pos_ff <= req_data.position;
         val_ff <= req_data.record_value[RECORD_BITS-1:0];
      end
      if (in_exec) begin
         status_ff <= status_in;
         freed_ff  <= dir_at_pos;
      end
      rsp_data_ff <= rsp_data_in;
      dir_ff      <= dir_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `SPRD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(SLOTS), "count above page size")
   `SPRD_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && !req_stall, state_ff == S_EXEC, "accepted item did not execute")
   `SPRD_ASSERT_NEXT(a_dirty_sticky, clock, reset, dirty_ff, dirty_ff, "dirty mark cleared")
   `SPRD_ASSERT_NEXT(a_count_exec_only, clock, reset, !in_exec, $stable(count_ff), "count changed outside execute")
   `SPRD_ASSERT_NOW(a_write_once, clock, reset, mem_wr_en, !mem_rd_en, "record write and read together")

endmodule

// ===== dv/tb_slotted_page_record_directory.sv =====
module tb_slotted_page_record_directory;
   import sprd_pkg::*;

   localparam int SLOT_COUNT   = 16;
   localparam int ITEM_TOTAL   = 1550;
   localparam int SETTLE_LIMIT = 16;     // cycles to wait after the last result
   localparam int IDLE_LIMIT   = 3000;   // cycles with no handshake before giving up
   localparam int HOLD_START   = 2500;   // monitor cycle where the long hold-off begins
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_LIMIT = 10;

   // Opcode 3 is not in the package; the block treats it as a no-op.
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} gen_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   slotted_page_record_directory #(
      .SLOTS       (SLOT_COUNT),
      .RECORD_BITS (64)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Items waiting to be offered, and answers the page should give, oldest first.
   req_type pending_items[$];
   rsp_type expected_rsp[$];

   // Shadow copy of the page: record store, slot directory, count, dirty mark.
   logic [63:0] page_rec [0:SLOT_COUNT-1];
   logic [3:0]  page_dir [0:SLOT_COUNT-1];
   logic [4:0]  page_count = '0;
   logic        page_dirty_mark = 1'b0;

   int plan_count     = 0;   // record count as the stimulus generator sees it
   int accepted_items = 0;
   int checked_rsp    = 0;
   int error_count    = 0;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   // Apply one accepted item to the shadow page and queue the answer it gives.
   task automatic page_apply(input req_type item);
      rsp_type answer;
      int      pos;
      int      last;
      int      freed;
      int      i;
      answer = '0;
      pos = item.position;
      case (item.op)
         OP_INSERT: begin
            // Full is tested before the position.
            if (page_count >= SLOT_COUNT) begin
               answer.status = ST_FULL;
            end else if (pos > page_count) begin
               answer.status = ST_RANGE;
            end else begin
               // Shift the directory up and place the record at the next free slot.
               for (i = page_count; i > pos; i--)
                  page_dir[i] = page_dir[i-1];
               page_dir[pos] = page_count[3:0];
               page_rec[page_count[3:0]] = item.record_value;
               page_count++;
               page_dirty_mark = 1'b1;
            end
         end
         OP_DELETE: begin
            if (pos >= page_count) begin
               answer.status = ST_RANGE;
            end else begin
               // Move the last physical record into the freed slot, close the
               // directory gap and renumber the entry that named the moved record.
               last  = page_count - 1;
               freed = page_dir[pos];
               if (freed != last)
                  page_rec[freed] = page_rec[last];
               for (i = 0; i < last; i++) begin
                  if (i >= pos)
                     page_dir[i] = page_dir[i+1];
                  if (page_dir[i] == last)
                     page_dir[i] = freed[3:0];
               end
               page_count = last[4:0];
               page_dirty_mark = 1'b1;
            end
         end
         OP_READ: begin
            if (pos >= page_count)
               answer.status = ST_RANGE;
            else
               answer.read_value = page_rec[page_dir[pos]];
         end
         default: ;   // no-op: report current state only
      endcase
      answer.record_count = page_count;
      answer.page_dirty   = page_dirty_mark;
      expected_rsp.push_back(answer);
   endtask

   // Queue one item and track the count it leaves, so later positions can aim
   // at the live range.
   task automatic queue_item(input logic [1:0] op, input int pos, input logic [63:0] value);
      req_type item;
      item.op           = op;
      item.position     = pos[3:0];
      item.record_value = value;
      pending_items.push_back(item);
      if (op == OP_INSERT && plan_count < SLOT_COUNT && pos <= plan_count)
         plan_count++;
      else if (op == OP_DELETE && pos < plan_count)
         plan_count--;
   endtask

   // Driver: offer items in bursts, hold each one until it is taken.
   int burst_left = 8;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_req
      logic    next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            page_apply(req_data);
            accepted_items++;
            next_valid = 1'b0;
         end
         // Hold a stalled item; otherwise idle through the gap or offer the next.
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               next_data  = pending_items.pop_front();
               next_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // Monitor: check each taken result against the oldest expectation and
   // drive the result stall from a pattern that changes every so often.
   int mon_cycles = 0;
   int stall_mode = 0;
   int stall_span = 0;
   int hold_left  = 0;

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      logic    next_stall;
      next_stall = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               flag_error($sformatf("result %0d arrived with nothing expected", checked_rsp));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status
                   || rsp_data.record_count !== want.record_count
                   || rsp_data.read_value !== want.read_value
                   || rsp_data.page_dirty !== want.page_dirty)
                  flag_error($sformatf(
                     "result %0d: status %0d/%0d count %0d/%0d read %h/%h dirty %0d/%0d (exp/act)",
                     checked_rsp, want.status, rsp_data.status,
                     want.record_count, rsp_data.record_count,
                     want.read_value, rsp_data.read_value,
                     want.page_dirty, rsp_data.page_dirty));
            end
            checked_rsp++;
         end

         mon_cycles++;
         // Hold off once for a long stretch so the block backs up into its input.
         if (mon_cycles == HOLD_START)
            hold_left = HOLD_CYCLES;
         if (stall_span <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 120);
         end
         stall_span--;
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            case (stall_mode)
               1:       next_stall = ($urandom_range(0, 3) == 0);
               2:       next_stall = ($urandom_range(0, 3) != 0);
               3:       next_stall = !rsp_stall;
               default: next_stall = 1'b0;
            endcase
         end
      end
      rsp_stall <= next_stall;
   end

   // Watchdog: give up after a long run of cycles with no handshake at all.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      gen_mode_type mode;
      int           span;
      int           roll;
      int           pos;
      int           k;
      logic [1:0]   op_code;
      logic [63:0]  value;

      // Directed: empty page answers, fill to full, full insert, top position.
      queue_item(OP_READ,   0, '0);
      queue_item(OP_DELETE, 0, '0);
      queue_item(OP_INSERT, 1, 64'hDEAD_BEEF_0000_0001);
      for (k = 0; k < SLOT_COUNT; k++) begin
         if (k == 0)
            value = '1;
         else if (k == 1)
            value = '0;
         else
            value = {$urandom, $urandom};
         case (k % 3)
            0:       pos = 0;
            1:       pos = plan_count;
            default: pos = plan_count / 2;
         endcase
         queue_item(OP_INSERT, pos, value);
      end
      queue_item(OP_INSERT, 15, {$urandom, $urandom});
      queue_item(OP_READ,   15, '0);
      queue_item(OP_DELETE, 15, '0);
      queue_item(OP_READ,   15, '0);
      queue_item(OP_DELETE, 0,  '0);
      queue_item(OP_NONE,   7,  '1);

      // Random: phases that lean toward filling, draining or a mix, with
      // positions mostly inside the live range and some noise anywhere.
      while (pending_items.size() < ITEM_TOTAL) begin
         mode = gen_mode_type'($urandom_range(0, 2));
         span = $urandom_range(15, 70);
         repeat (span) begin
            roll = $urandom_range(0, 99);
            case (mode)
               MODE_FILL:
                  op_code = (roll < 65) ? OP_INSERT : (roll < 80) ? OP_DELETE :
                            (roll < 97) ? OP_READ : OP_NONE;
               MODE_DRAIN:
                  op_code = (roll < 20) ? OP_INSERT : (roll < 70) ? OP_DELETE :
                            (roll < 97) ? OP_READ : OP_NONE;
               default:
                  op_code = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_DELETE :
                            (roll < 97) ? OP_READ : OP_NONE;
            endcase
            if ($urandom_range(0, 9) == 0)
               pos = $urandom_range(0, 15);
            else if (op_code == OP_INSERT)
               pos = $urandom_range(0, (plan_count > 15) ? 15 : plan_count);
            else if (plan_count == 0)
               pos = $urandom_range(0, 15);
            else
               pos = $urandom_range(0, plan_count - 1);
            roll = $urandom_range(0, 9);
            value = (roll == 0) ? '1 : (roll == 1) ? '0 : {$urandom, $urandom};
            queue_item(op_code, pos, value);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to be taken, including the last one still on
      // offer, and every answer to come back.
      while (accepted_items < ITEM_TOTAL || pending_items.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_LIMIT) @(posedge clock);

      if (expected_rsp.size() != 0)
         flag_error($sformatf("%0d expected results never arrived", expected_rsp.size()));
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
